@@ rtl/qslerp_pkg.sv @@
// ---------------------------------------------------------------------------
// qslerp_pkg
// Shared types, constants and the arctangent table for the slerp pipeline.
// ---------------------------------------------------------------------------
package qslerp_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int ANG_W        = 33;   // signed Q2.30 angle with headroom
    localparam int CV_W         = 34;   // signed CORDIC vector component

    typedef logic [30:0]              unorm_t;   // unsigned Q1.30, 0 .. 1.0
    typedef logic signed [ANG_W-1:0]  angle_t;
    typedef logic signed [CV_W-1:0]   cvec_t;

    typedef struct packed {
        logic en;      // pipeline advance
        logic valid;   // word entering the unit
    } pipe_ctl_t;

    localparam unorm_t      ONE_Q30     = 31'h4000_0000;
    localparam unorm_t      THETA_MIN   = 31'd1074;
    localparam logic [16:0] BLEND_ONE   = 17'd65536;
    localparam cvec_t       CORDIC_GAIN = 34'sd652032874;

    function automatic angle_t atan_entry(input int idx);
        angle_t val;
        case (idx)
            0:  val = 33'sd843314856;
            1:  val = 33'sd497837829;
            2:  val = 33'sd263043836;
            3:  val = 33'sd133525158;
            4:  val = 33'sd67021686;
            5:  val = 33'sd33543515;
            6:  val = 33'sd16775850;
            7:  val = 33'sd8388437;
            8:  val = 33'sd4194282;
            9:  val = 33'sd2097149;
            10: val = 33'sd1048575;
            11: val = 33'sd524287;
            12: val = 33'sd262143;
            13: val = 33'sd131071;
            14: val = 33'sd65535;
            15: val = 33'sd32767;
            16: val = 33'sd16383;
            17: val = 33'sd8191;
            18: val = 33'sd4095;
            19: val = 33'sd2047;
            20: val = 33'sd1023;
            21: val = 33'sd511;
            22: val = 33'sd255;
            23: val = 33'sd127;
            24: val = 33'sd63;
            25: val = 33'sd31;
            26: val = 33'sd15;
            27: val = 33'sd8;
            28: val = 33'sd4;
            29: val = 33'sd2;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/qslerp_sqrt.sv @@
// ---------------------------------------------------------------------------
// qslerp_sqrt
// Pipelined floor square root, one root bit per stage, 31 stages.
// ---------------------------------------------------------------------------
module qslerp_sqrt
    import qslerp_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_ctl_t         ctl,
    input  logic [60:0]       rad,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output unorm_t            root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int STAGES = 31;

    logic [62:0]       rem_reg  [STAGES-1];
    unorm_t            root_reg [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];
    logic              valid_reg [STAGES];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        localparam int K = STAGES - 1 - g;
        logic [62:0]       rem_cur;
        logic [62:0]       rem_next;
        logic [62:0]       trial;
        unorm_t            root_cur;
        unorm_t            root_next;
        logic [SIDE_W-1:0] side_cur;
        logic              valid_cur;

        if (g == 0)
        begin : g_head
            assign rem_cur   = 63'(rad);
            assign root_cur  = '0;
            assign side_cur  = side_in;
            assign valid_cur = ctl.valid;
        end
        else
        begin : g_tail
            assign rem_cur   = rem_reg[g-1];
            assign root_cur  = root_reg[g-1];
            assign side_cur  = side_reg[g-1];
            assign valid_cur = valid_reg[g-1];
        end

        // trial = (2r + 2^K) * 2^K
        always_comb
        begin
            trial = (63'(root_cur) << (K + 1)) + (63'(1) << (2 * K));
            if (rem_cur >= trial)
            begin
                rem_next  = rem_cur - trial;
                root_next = root_cur | (31'(1) << K);
            end
            else
            begin
                rem_next  = rem_cur;
                root_next = root_cur;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (ctl.en)
                valid_reg[g] <= valid_cur;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                root_reg[g] <= root_next;
                side_reg[g] <= side_cur;
            end
        end

        if (g < STAGES - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (ctl.en)
                    rem_reg[g] <= rem_next;
            end
        end
    end

    assign valid_out = valid_reg[STAGES-1];
    assign root      = root_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

@@ rtl/qslerp_vec.sv @@
// ---------------------------------------------------------------------------
// qslerp_vec
// Vectoring CORDIC: angle of (x, y), one micro-rotation per stage.
// ---------------------------------------------------------------------------
module qslerp_vec
    import qslerp_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_ctl_t         ctl,
    input  unorm_t            x,
    input  unorm_t            y,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output angle_t            angle,
    output logic [SIDE_W-1:0] side_out
);

    localparam int N = CORDIC_STEPS;

    cvec_t             x_reg [N-1];
    cvec_t             y_reg [N-1];
    angle_t            z_reg [N];
    logic [SIDE_W-1:0] side_reg [N];
    logic              valid_reg [N];

    for (genvar g = 0; g < N; g++)
    begin : g_step
        cvec_t             x_cur;
        cvec_t             y_cur;
        cvec_t             x_next;
        cvec_t             y_next;
        angle_t            z_cur;
        angle_t            z_next;
        logic [SIDE_W-1:0] side_cur;
        logic              valid_cur;

        if (g == 0)
        begin : g_head
            assign x_cur     = cvec_t'(x);
            assign y_cur     = cvec_t'(y);
            assign z_cur     = '0;
            assign side_cur  = side_in;
            assign valid_cur = ctl.valid;
        end
        else
        begin : g_tail
            assign x_cur     = x_reg[g-1];
            assign y_cur     = y_reg[g-1];
            assign z_cur     = z_reg[g-1];
            assign side_cur  = side_reg[g-1];
            assign valid_cur = valid_reg[g-1];
        end

        always_comb
        begin
            if (!y_cur[CV_W-1])
            begin
                x_next = x_cur + (y_cur >>> g);
                y_next = y_cur - (x_cur >>> g);
                z_next = z_cur + atan_entry(g);
            end
            else
            begin
                x_next = x_cur - (y_cur >>> g);
                y_next = y_cur + (x_cur >>> g);
                z_next = z_cur - atan_entry(g);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (ctl.en)
                valid_reg[g] <= valid_cur;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                z_reg[g]    <= z_next;
                side_reg[g] <= side_cur;
            end
        end

        if (g < N - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    x_reg[g] <= x_next;
                    y_reg[g] <= y_next;
                end
            end
        end
    end

    assign valid_out = valid_reg[N-1];
    assign angle     = z_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

@@ rtl/qslerp_rot.sv @@
// ---------------------------------------------------------------------------
// qslerp_rot
// Rotation CORDIC: sine of an angle, gain pre-compensated, 30 stages.
// ---------------------------------------------------------------------------
module qslerp_rot
    import qslerp_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_ctl_t         ctl,
    input  angle_t            angle,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output cvec_t             sine,
    output logic [SIDE_W-1:0] side_out
);

    localparam int N = CORDIC_STEPS;

    cvec_t             x_reg [N-1];
    cvec_t             y_reg [N];
    angle_t            z_reg [N-1];
    logic [SIDE_W-1:0] side_reg [N];
    logic              valid_reg [N];

    for (genvar g = 0; g < N; g++)
    begin : g_step
        cvec_t             x_cur;
        cvec_t             y_cur;
        cvec_t             x_next;
        cvec_t             y_next;
        angle_t            z_cur;
        angle_t            z_next;
        logic [SIDE_W-1:0] side_cur;
        logic              valid_cur;

        if (g == 0)
        begin : g_head
            assign x_cur     = CORDIC_GAIN;
            assign y_cur     = '0;
            assign z_cur     = angle;
            assign side_cur  = side_in;
            assign valid_cur = ctl.valid;
        end
        else
        begin : g_tail
            assign x_cur     = x_reg[g-1];
            assign y_cur     = y_reg[g-1];
            assign z_cur     = z_reg[g-1];
            assign side_cur  = side_reg[g-1];
            assign valid_cur = valid_reg[g-1];
        end

        always_comb
        begin
            if (!z_cur[ANG_W-1])
            begin
                x_next = x_cur - (y_cur >>> g);
                y_next = y_cur + (x_cur >>> g);
                z_next = z_cur - atan_entry(g);
            end
            else
            begin
                x_next = x_cur + (y_cur >>> g);
                y_next = y_cur - (x_cur >>> g);
                z_next = z_cur + atan_entry(g);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (ctl.en)
                valid_reg[g] <= valid_cur;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                y_reg[g]    <= y_next;
                side_reg[g] <= side_cur;
            end
        end

        if (g < N - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    x_reg[g] <= x_next;
                    z_reg[g] <= z_next;
                end
            end
        end
    end

    assign valid_out = valid_reg[N-1];
    assign sine      = y_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

@@ rtl/qslerp_div.sv @@
// ---------------------------------------------------------------------------
// qslerp_div
// Restoring divider for num * 2^30 / den, one quotient bit per stage,
// result clamped to 1.0.
// ---------------------------------------------------------------------------
module qslerp_div
    import qslerp_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_ctl_t         ctl,
    input  unorm_t            num,
    input  unorm_t            den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output unorm_t            quot,
    output logic [SIDE_W-1:0] side_out
);

    localparam int STAGES = 31;

    logic [61:0]       rem_reg [STAGES-1];
    unorm_t            den_reg [STAGES-1];
    unorm_t            q_reg   [STAGES];
    logic              ovf_reg [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];
    logic              valid_reg [STAGES];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        localparam int K = STAGES - 1 - g;
        logic [61:0]       rem_cur;
        logic [61:0]       rem_next;
        logic [61:0]       dshift;
        unorm_t            den_cur;
        unorm_t            q_cur;
        unorm_t            q_next;
        logic              ovf_cur;
        logic [SIDE_W-1:0] side_cur;
        logic              valid_cur;

        if (g == 0)
        begin : g_head
            // quotient of 2^31 or more saturates anyway
            assign ovf_cur   = {1'b0, num} >= {den, 1'b0};
            assign rem_cur   = {1'b0, num, 30'b0};
            assign den_cur   = den;
            assign q_cur     = '0;
            assign side_cur  = side_in;
            assign valid_cur = ctl.valid;
        end
        else
        begin : g_tail
            assign ovf_cur   = ovf_reg[g-1];
            assign rem_cur   = rem_reg[g-1];
            assign den_cur   = den_reg[g-1];
            assign q_cur     = q_reg[g-1];
            assign side_cur  = side_reg[g-1];
            assign valid_cur = valid_reg[g-1];
        end

        always_comb
        begin
            dshift = 62'(den_cur) << K;
            if (rem_cur >= dshift)
            begin
                rem_next = rem_cur - dshift;
                q_next   = q_cur | (31'(1) << K);
            end
            else
            begin
                rem_next = rem_cur;
                q_next   = q_cur;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (ctl.en)
                valid_reg[g] <= valid_cur;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                q_reg[g]    <= q_next;
                ovf_reg[g]  <= ovf_cur;
                side_reg[g] <= side_cur;
            end
        end

        if (g < STAGES - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    rem_reg[g] <= rem_next;
                    den_reg[g] <= den_cur;
                end
            end
        end
    end

    assign valid_out = valid_reg[STAGES-1];
    assign quot      = (ovf_reg[STAGES-1] || q_reg[STAGES-1] > ONE_Q30)
                     ? ONE_Q30 : q_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

@@ rtl/quaternion_slerp_top.sv @@
// ---------------------------------------------------------------------------
// quaternion_slerp_top
// Shortest-path quaternion slerp, fixed point, fully pipelined.
// ---------------------------------------------------------------------------
// Usage notes
//  - Input channel item_valid / item_stall carries one word: start and end
//    quaternions (signed, FRACTION_BITS fractional bits) and blend (Q1.16,
//    values above 1.0 are taken as 1.0).
//  - Output channel result_valid / result_stall returns one interpolated
//    quaternion per input word, in order, rounded and saturated.
//  - Throughput: one word per cycle, sustained while the output is not
//    stalled. The depth comes from the 31-stage square root, the
//    30-stage vectoring CORDIC, the two parallel 30-stage rotation
//    CORDICs and the two parallel 31-stage dividers.
//  - A stalled output word is held in the output register; while it waits
//    the whole pipeline freezes and item_stall is raised. Bubbles are
//    carried as invalid stages, never as lost or repeated words.
//  - Reset (rst_n low, asynchronous) clears every valid bit; the datapath
//    needs no clearing and the block accepts words from the first cycle.
//  - No configuration and no state between words.
// ---------------------------------------------------------------------------
module quaternion_slerp_top
    import qslerp_pkg::*;
#(
    parameter int COMPONENT_BITS = 16,
    parameter int FRACTION_BITS  = 14
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic signed [COMPONENT_BITS-1:0] start_w,
    input  logic signed [COMPONENT_BITS-1:0] start_x,
    input  logic signed [COMPONENT_BITS-1:0] start_y,
    input  logic signed [COMPONENT_BITS-1:0] start_z,
    input  logic signed [COMPONENT_BITS-1:0] end_w,
    input  logic signed [COMPONENT_BITS-1:0] end_x,
    input  logic signed [COMPONENT_BITS-1:0] end_y,
    input  logic signed [COMPONENT_BITS-1:0] end_z,
    input  logic        [16:0]               blend,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic signed [COMPONENT_BITS-1:0] out_w,
    output logic signed [COMPONENT_BITS-1:0] out_x,
    output logic signed [COMPONENT_BITS-1:0] out_y,
    output logic signed [COMPONENT_BITS-1:0] out_z
);

    localparam int CB  = COMPONENT_BITS;
    localparam int BCW = COMPONENT_BITS + 1;       // end component after negation
    localparam int PW  = 2 * COMPONENT_BITS;       // exact product / dot width
    localparam int DW  = 2 * COMPONENT_BITS + 32;  // dot rescale headroom
    localparam int SHL = (2 * FRACTION_BITS - 2 >= 30) ? 0 : 32 - 2 * FRACTION_BITS;
    localparam int SHR = (2 * FRACTION_BITS - 2 >= 30) ? 2 * FRACTION_BITS - 32 : 0;
    localparam int AW  = 4 * COMPONENT_BITS;
    localparam int BW  = 4 * (COMPONENT_BITS + 1);
    localparam int M0W = COMPONENT_BITS + 32;
    localparam int M1W = COMPONENT_BITS + 33;
    localparam int SW  = COMPONENT_BITS + 34;
    localparam logic [DW-1:0] ONE_DOT = DW'(1) << (2 * FRACTION_BITS - 2);
    localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (CB - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV = -(SW'(1) <<< (CB - 1));
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< 29;

    // global advance: frozen only while a finished word is held
    logic      en;
    logic      result_valid_reg;

    assign en         = !result_valid_reg || !result_stall;
    assign item_stall = !en;

    // ---- stage 1: component products -------------------------------------
    logic [3:0][CB-1:0] a_in;
    logic [3:0][CB-1:0] b_in;
    logic [3:0][PW-1:0] s1_prod_next;
    logic [3:0][PW-1:0] s1_prod_reg;
    logic [3:0][CB-1:0] s1_a_reg;
    logic [3:0][CB-1:0] s1_b_reg;
    logic [16:0]        s1_t_next;
    logic [16:0]        s1_t_reg;
    logic               s1_valid_reg;

    assign a_in = {start_z, start_y, start_x, start_w};
    assign b_in = {end_z, end_y, end_x, end_w};

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            s1_prod_next[i] = PW'(signed'(a_in[i])) * PW'(signed'(b_in[i]));
        s1_t_next = (blend > BLEND_ONE) ? BLEND_ONE : blend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_a_reg    <= a_in;
            s1_b_reg    <= b_in;
            s1_t_reg    <= s1_t_next;
        end
    end

    // ---- stage 2: dot product, short-arc flip, cosine in Q1.30 -------------
    logic signed [PW-1:0] dot;
    logic                 dot_neg;
    logic [PW-1:0]        dot_mag;
    logic [DW-1:0]        dot_wide;
    logic [DW-1:0]        dot_scaled;
    unorm_t               s2_c_next;
    unorm_t               s2_c_reg;
    logic [3:0][BCW-1:0]  s2_b_next;
    logic [3:0][BCW-1:0]  s2_b_reg;
    logic [3:0][CB-1:0]   s2_a_reg;
    logic [16:0]          s2_t_reg;
    logic                 s2_valid_reg;

    always_comb
    begin
        dot = '0;
        for (int i = 0; i < 4; i++)
            dot = dot + (signed'(s1_prod_reg[i]) >>> 2);
        dot_neg    = dot[PW-1];
        dot_mag    = dot_neg ? PW'(-dot) : PW'(dot);
        dot_wide   = DW'(dot_mag);
        dot_scaled = (dot_wide << SHL) >> SHR;
        s2_c_next  = (dot_wide >= ONE_DOT) ? ONE_Q30 : dot_scaled[30:0];
        for (int i = 0; i < 4; i++)
            s2_b_next[i] = dot_neg ? -BCW'(signed'(s1_b_reg[i]))
                                   :  BCW'(signed'(s1_b_reg[i]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_c_reg <= s2_c_next;
            s2_b_reg <= s2_b_next;
            s2_a_reg <= s1_a_reg;
            s2_t_reg <= s1_t_reg;
        end
    end

    // ---- stage 3: radicand (1 - c)(1 + c) ----------------------------------
    logic [31:0]         c_lo;
    logic [31:0]         c_hi;
    logic [63:0]         rad_full;
    logic [60:0]         s3_rad_reg;
    unorm_t              s3_c_reg;
    logic [3:0][CB-1:0]  s3_a_reg;
    logic [3:0][BCW-1:0] s3_b_reg;
    logic [16:0]         s3_t_reg;
    logic                s3_valid_reg;

    assign c_lo     = 32'(ONE_Q30) - 32'(s2_c_reg);
    assign c_hi     = 32'(ONE_Q30) + 32'(s2_c_reg);
    assign rad_full = c_lo * c_hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_rad_reg <= rad_full[60:0];
            s3_c_reg   <= s2_c_reg;
            s3_a_reg   <= s2_a_reg;
            s3_b_reg   <= s2_b_reg;
            s3_t_reg   <= s2_t_reg;
        end
    end

    // ---- sine of theta ----------------------------------------------------
    pipe_ctl_t           sq_ctl;
    logic                sq_valid;
    unorm_t              sq_s;
    unorm_t              sq_c;
    logic [3:0][CB-1:0]  sq_a;
    logic [3:0][BCW-1:0] sq_b;
    logic [16:0]         sq_t;

    assign sq_ctl = '{en: en, valid: s3_valid_reg};

    qslerp_sqrt #(
        .SIDE_W(31 + AW + BW + 17)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sq_ctl),
        .rad      (s3_rad_reg),
        .side_in  ({s3_c_reg, s3_a_reg, s3_b_reg, s3_t_reg}),
        .valid_out(sq_valid),
        .root     (sq_s),
        .side_out ({sq_c, sq_a, sq_b, sq_t})
    );

    // ---- theta = atan2(s, c) -----------------------------------------------
    pipe_ctl_t           vec_ctl;
    logic                vec_valid;
    angle_t              vec_theta;
    unorm_t              vec_s;
    logic [3:0][CB-1:0]  vec_a;
    logic [3:0][BCW-1:0] vec_b;
    logic [16:0]         vec_t;

    assign vec_ctl = '{en: en, valid: sq_valid};

    qslerp_vec #(
        .SIDE_W(31 + AW + BW + 17)
    ) u_vec (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (vec_ctl),
        .x        (sq_c),
        .y        (sq_s),
        .side_in  ({sq_s, sq_a, sq_b, sq_t}),
        .valid_out(vec_valid),
        .angle    (vec_theta),
        .side_out ({vec_s, vec_a, vec_b, vec_t})
    );

    // ---- partial angles (1-t)theta and t theta -----------------------------
    unorm_t              theta;
    logic [47:0]         ang0_full;
    logic [47:0]         ang1_full;
    angle_t              sa_ang0_reg;
    angle_t              sa_ang1_reg;
    logic                sa_flag_reg;
    unorm_t              sa_s_reg;
    logic [3:0][CB-1:0]  sa_a_reg;
    logic [3:0][BCW-1:0] sa_b_reg;
    logic [16:0]         sa_t_reg;
    logic                sa_valid_reg;

    assign theta     = vec_theta[ANG_W-1] ? '0 : vec_theta[30:0];
    assign ang0_full = 48'(BLEND_ONE - vec_t) * 48'(theta);
    assign ang1_full = 48'(vec_t) * 48'(theta);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sa_valid_reg <= 1'b0;
        else if (en)
            sa_valid_reg <= vec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_ang0_reg <= angle_t'(ang0_full[46:16]);
            sa_ang1_reg <= angle_t'(ang1_full[46:16]);
            // tiny angle or zero sine: linear blend
            sa_flag_reg <= (theta >= THETA_MIN) && (vec_s != '0);
            sa_s_reg    <= vec_s;
            sa_a_reg    <= vec_a;
            sa_b_reg    <= vec_b;
            sa_t_reg    <= vec_t;
        end
    end

    // ---- sines of the partial angles ---------------------------------------
    pipe_ctl_t           rot_ctl;
    logic                rot0_valid;
    logic                rot1_valid;
    cvec_t               rot0_sin;
    cvec_t               rot1_sin;
    unorm_t              rot_s;
    logic [3:0][CB-1:0]  rot_a;
    logic [3:0][BCW-1:0] rot_b;
    logic                rot_flag;
    logic [16:0]         rot_t;

    assign rot_ctl = '{en: en, valid: sa_valid_reg};

    qslerp_rot #(
        .SIDE_W(31 + AW + BW)
    ) u_rot0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rot_ctl),
        .angle    (sa_ang0_reg),
        .side_in  ({sa_s_reg, sa_a_reg, sa_b_reg}),
        .valid_out(rot0_valid),
        .sine     (rot0_sin),
        .side_out ({rot_s, rot_a, rot_b})
    );

    qslerp_rot #(
        .SIDE_W(18)
    ) u_rot1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rot_ctl),
        .angle    (sa_ang1_reg),
        .side_in  ({sa_flag_reg, sa_t_reg}),
        .valid_out(rot1_valid),
        .sine     (rot1_sin),
        .side_out ({rot_flag, rot_t})
    );

    // ---- clamp sines to [0, 1] ---------------------------------------------
    function automatic unorm_t clamp_unit(input cvec_t v);
        unorm_t r;
        if (v[CV_W-1])
            r = '0;
        else if (v > cvec_t'(ONE_Q30))
            r = ONE_Q30;
        else
            r = v[30:0];
        return r;
    endfunction

    unorm_t              sn_sin0_reg;
    unorm_t              sn_sin1_reg;
    unorm_t              sn_s_reg;
    logic [3:0][CB-1:0]  sn_a_reg;
    logic [3:0][BCW-1:0] sn_b_reg;
    logic                sn_flag_reg;
    logic [16:0]         sn_t_reg;
    logic                sn_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sn_valid_reg <= 1'b0;
        else if (en)
            sn_valid_reg <= rot0_valid && rot1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn_sin0_reg <= clamp_unit(rot0_sin);
            sn_sin1_reg <= clamp_unit(rot1_sin);
            sn_s_reg    <= rot_s;
            sn_a_reg    <= rot_a;
            sn_b_reg    <= rot_b;
            sn_flag_reg <= rot_flag;
            sn_t_reg    <= rot_t;
        end
    end

    // ---- weights sin(.)/sin(theta) -----------------------------------------
    pipe_ctl_t           div_ctl;
    logic                div0_valid;
    logic                div1_valid;
    unorm_t              div_q0;
    unorm_t              div_q1;
    logic                div_flag;
    logic [16:0]         div_t;
    logic [3:0][CB-1:0]  div_a;
    logic [3:0][BCW-1:0] div_b;

    assign div_ctl = '{en: en, valid: sn_valid_reg};

    qslerp_div #(
        .SIDE_W(1 + 17 + AW)
    ) u_div0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .num      (sn_sin0_reg),
        .den      (sn_s_reg),
        .side_in  ({sn_flag_reg, sn_t_reg, sn_a_reg}),
        .valid_out(div0_valid),
        .quot     (div_q0),
        .side_out ({div_flag, div_t, div_a})
    );

    qslerp_div #(
        .SIDE_W(BW)
    ) u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .num      (sn_sin1_reg),
        .den      (sn_s_reg),
        .side_in  (sn_b_reg),
        .valid_out(div1_valid),
        .quot     (div_q1),
        .side_out (div_b)
    );

    // ---- weight select -----------------------------------------------------
    unorm_t              w_w0_reg;
    unorm_t              w_w1_reg;
    logic                w_flag_reg;
    logic [3:0][CB-1:0]  w_a_reg;
    logic [3:0][BCW-1:0] w_b_reg;
    logic                w_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_valid_reg <= 1'b0;
        else if (en)
            w_valid_reg <= div0_valid && div1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_w0_reg   <= div_flag ? div_q0 : (31'(BLEND_ONE - div_t) << 14);
            w_w1_reg   <= div_flag ? div_q1 : (31'(div_t) << 14);
            w_flag_reg <= div_flag;
            w_a_reg    <= div_a;
            w_b_reg    <= div_b;
        end
    end

    // ---- weighted products -------------------------------------------------
    logic signed [31:0]  w0_s;
    logic signed [31:0]  w1_s;
    logic [3:0][M0W-1:0] m_p0_reg;
    logic [3:0][M1W-1:0] m_p1_reg;
    logic                m_valid_reg;

    assign w0_s = signed'({1'b0, w_w0_reg});
    assign w1_s = signed'({1'b0, w_w1_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= w_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                m_p0_reg[i] <= M0W'(w0_s) * M0W'(signed'(w_a_reg[i]));
                m_p1_reg[i] <= M1W'(w1_s) * M1W'(signed'(w_b_reg[i]));
            end
        end
    end

    // ---- round, scale, saturate into the output register -------------------
    logic [3:0][CB-1:0]   res_next;
    logic [3:0][CB-1:0]   res_reg;
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] scaled;

    always_comb
    begin
        acc    = '0;
        scaled = '0;
        for (int i = 0; i < 4; i++)
        begin
            acc    = SW'(signed'(m_p0_reg[i])) + SW'(signed'(m_p1_reg[i])) + HALF;
            scaled = acc >>> 30;
            if (scaled > MAXV)
                res_next[i] = MAXV[CB-1:0];
            else if (scaled < MINV)
                res_next[i] = MINV[CB-1:0];
            else
                res_next[i] = scaled[CB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (en)
            result_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign result_valid = result_valid_reg;
    assign out_w        = signed'(res_reg[0]);
    assign out_x        = signed'(res_reg[1]);
    assign out_y        = signed'(res_reg[2]);
    assign out_z        = signed'(res_reg[3]);

    // ---- checks ------------------------------------------------------------
    a_cos_unit: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> s2_c_reg <= ONE_Q30)
        else $error("cosine above one");

    a_lanes_rot: assert property (@(posedge clk) disable iff (!rst_n)
        rot0_valid == rot1_valid)
        else $error("sine lanes out of step");

    a_lanes_div: assert property (@(posedge clk) disable iff (!rst_n)
        div0_valid == div1_valid)
        else $error("divider lanes out of step");

    a_weight_unit: assert property (@(posedge clk) disable iff (!rst_n)
        w_valid_reg |-> (w_w0_reg <= ONE_Q30 && w_w1_reg <= ONE_Q30))
        else $error("weight above one");

    a_linear_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (w_valid_reg && !w_flag_reg) |-> (32'(w_w0_reg) + 32'(w_w1_reg) == 32'(ONE_Q30)))
        else $error("linear weights do not sum to one");

endmodule
